@@ rtl/olt_pkg.sv @@
package olt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_APPEND  = 2'd0;
    localparam logic [1:0] REQ_PREPEND = 2'd1;
    localparam logic [1:0] REQ_DELETE  = 2'd2;
    localparam logic [1:0] REQ_SEARCH  = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic       overflow;
        logic [4:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } t_cmd;

endpackage

@@ rtl/olt_ctrl.sv @@
module olt_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output olt_pkg::t_cmd o_cmd
);
    import olt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/olt_dp.sv @@
module olt_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  olt_pkg::t_cmd i_cmd,
    input  olt_pkg::t_req i_req,
    output olt_pkg::t_rsp o_rsp
);
    import olt_pkg::*;

    t_req              r_req;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [CAPACITY-1:0] r_match;
    logic [CAPACITY-1:0] n_match;
    logic [31:0]       r_ent [CAPACITY];
    logic [31:0]       n_ent [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CAPACITY-1:0] lowest;
    logic [CAPACITY-1:0] below;
    logic              any_match;
    logic              full;
    logic [CNT_W+4:0]  count_ext;

    assign o_rsp = r_rsp;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = (r_ent[i] == r_req.value) && (CNT_W'(i) < r_count);
        end
    end

    assign lowest    = r_match & (~r_match + 1'b1);
    assign below     = lowest - 1'b1;
    assign any_match = |r_match;
    assign full      = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_ent   = r_ent;
        n_count = r_count;
        n_rsp   = '0;
        case (r_req.req_type)
            REQ_APPEND: begin
                if (full) begin
                    n_rsp.overflow = 1'b1;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (r_count == CNT_W'(i)) begin
                            n_ent[i] = r_req.value;
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PREPEND: begin
                if (full) begin
                    n_rsp.overflow = 1'b1;
                end else begin
                    n_ent[0] = r_req.value;
                    for (int i = 1; i < CAPACITY; i++) begin
                        n_ent[i] = r_ent[i-1];
                    end
                    n_count = r_count + 1'b1;
                end
            end
            REQ_DELETE: begin
                if (any_match) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!below[i]) begin
                            n_ent[i] = r_ent[i+1];
                        end
                    end
                    n_count   = r_count - 1'b1;
                    n_rsp.hit = 1'b1;
                end
            end
            default: begin
                n_rsp.hit = any_match;
            end
        endcase
        count_ext         = {5'b0, n_count};
        n_rsp.entry_count = count_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.compare) begin
            r_match <= n_match;
        end
        if (i_cmd.update) begin
            r_ent <= n_ent;
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/ordered_list_table_top.sv @@
// Each item passes the capture, then a parallel compare of all entries that registers the
// match vector, then the table update, which registers the result and sets the output valid.
// The controller steps one item at a time and takes no new item until the last has been updated.
// A new item is taken while the previous result still waits in the output register; the
// update then waits for that register to free, so an output stall holds the update back.
// Synchronous active-low reset empties the table and clears the output valid.
module ordered_list_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  olt_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output olt_pkg::t_rsp o_out_rsp
);
    import olt_pkg::*;

    t_cmd cmd;

    olt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    olt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

endmodule

@@ test/tb_ordered_list_table_top.sv @@
module tb_ordered_list_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_TAIL = 200;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    class olt_scoreboard;
        logic signed [31:0] list_q[$];
        t_rsp pending_q[$];
        int errors;
        int op_count[4];
        int hits;
        int overflows;
        int peak;
        int checked;

        function void note_request(input t_req req);
            t_rsp rsp;
            int idx;
            rsp = '0;
            idx = -1;
            op_count[req.req_type]++;
            case (req.req_type)
                REQ_APPEND, REQ_PREPEND: begin
                    if (list_q.size() >= CAPACITY) begin
                        rsp.overflow = 1'b1;
                    end else if (req.req_type == REQ_APPEND) begin
                        list_q.push_back(req.value);
                    end else begin
                        list_q.push_front(req.value);
                    end
                end
                default: begin
                    foreach (list_q[i]) begin
                        if (idx < 0 && list_q[i] == req.value) idx = i;
                    end
                    rsp.hit = (idx >= 0);
                    if (req.req_type == REQ_DELETE && idx >= 0) list_q.delete(idx);
                end
            endcase
            rsp.entry_count = 5'(list_q.size());
            if (rsp.hit) hits++;
            if (rsp.overflow) overflows++;
            if (list_q.size() > peak) peak = list_q.size();
            pending_q.push_back(rsp);
        endfunction

        function void check_response(input t_rsp got);
            t_rsp want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_req   i_in_req = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_rsp   o_out_rsp;

    olt_scoreboard sb;
    int cycle_count = 0;
    int sink_stall = 0;
    bit source_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    ordered_list_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ordered_list_table_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_response(o_out_rsp);
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            i_out_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(1, 18) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int source_gap();
        if (source_idle_on && $urandom_range(0, 7) == 0) return $urandom_range(1, 18);
        return 0;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'($urandom_range(1, 6));
            endcase
        end
        if (r < 7 && sb.list_q.size() > 0) return sb.list_q[$urandom_range(0, sb.list_q.size() - 1)];
        return $urandom;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic signed [31:0] val);
        t_req req;
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.req_type = op;
        req.value = val;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int mode;
        int r;
        int sent;
        logic [1:0] op;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_SEARCH, 32'sd0);
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_APPEND, VAL_MAX);
        send_request(REQ_PREPEND, VAL_MIN);
        send_request(REQ_APPEND, 32'sd0);
        send_request(REQ_APPEND, -32'sd1);
        send_request(REQ_PREPEND, 32'sd0);
        send_request(REQ_SEARCH, -32'sd1);
        send_request(REQ_SEARCH, 32'sd1);
        send_request(REQ_DELETE, 32'sd0);
        send_request(REQ_SEARCH, 32'sd0);
        send_request(REQ_DELETE, 32'sd123);
        for (int i = 0; i < 12; i++) send_request(REQ_APPEND, 32'(i * 7 - 20));
        send_request(REQ_APPEND, 32'sd99);
        send_request(REQ_PREPEND, 32'sd98);
        drain_results();

        sent = 0;
        mode = 1;
        while (sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - sent <= QUIET_TAIL) begin
                source_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end else begin
                source_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            for (int k = 0; k < 40 && sent < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 9);
                case (mode)
                    0: op = (r < 7) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
                    1: op = (r < 6) ? REQ_DELETE : (r < 8) ? REQ_SEARCH
                                                          : 2'($urandom_range(0, 1));
                    default: op = 2'($urandom_range(0, 3));
                endcase
                send_request(op, pick_value());
                sent++;
            end
            if ($urandom_range(0, 4) == 0) drain_results();
            mode = $urandom_range(0, 2);
        end
        i_in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results: %0d appends, %0d prepends, %0d deletes, %0d searches.",
                 sb.checked, sb.op_count[REQ_APPEND], sb.op_count[REQ_PREPEND],
                 sb.op_count[REQ_DELETE], sb.op_count[REQ_SEARCH]);
        $display("The run saw %0d hits, %0d dropped inserts and a peak of %0d entries.",
                 sb.hits, sb.overflows, sb.peak);
        if (sb.errors == 0) begin
            $display("ordered_list_table_top: match");
        end else begin
            $display("ordered_list_table_top: mismatch");
        end
        $finish;
    end

endmodule
